// ===== src/ksjc_pkg.sv =====
// shared types and constants for the k-step minimum jump cost unit
// no dependencies; used by every module in src
package ksjc_pkg;

   localparam int MAX_JUMP    = 16;
   localparam int HEIGHT_W    = 16;
   localparam int COST_W      = 32;
   localparam int JUMP_W      = 5;
   localparam int FILL_W      = $clog2(MAX_JUMP + 1);
   localparam int CMP_W       = (FILL_W > JUMP_W) ? FILL_W : JUMP_W;
   localparam int TREE_LEVELS = (MAX_JUMP > 1) ? $clog2(MAX_JUMP) : 1;
   localparam int TREE_SIZE   = 1 << TREE_LEVELS;
   localparam int LVL_W       = $clog2(TREE_LEVELS + 1);

   localparam logic [COST_W-1:0] COST_TOP       = {COST_W{1'b1}};
   localparam logic [JUMP_W-1:0] MAX_JUMP_RESET = JUMP_W'(2);

   typedef struct packed {
      logic signed [HEIGHT_W-1:0] height;
      logic                       last_stone;
   } ksjc_req_type;

   typedef struct packed {
      logic [COST_W-1:0] reach_cost;
      logic              is_final;
   } ksjc_rsp_type;

   typedef struct packed {
      logic shift;
      logic clear;
   } ksjc_cell_ctrl_type;

   typedef struct packed {
      logic load;
      logic step;
   } ksjc_tree_ctrl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CAND,
      ST_REDUCE,
      ST_DONE
   } ksjc_state_type;

endpackage

// ===== src/ksjc_cell.sv =====
// one window cell: holds a stone height and its cost, shifts them to the next cell
// and offers the jump candidate for the current stone; uses ksjc_pkg
module ksjc_cell (
   input  logic                                clock,
   input  logic                                reset,
   input  ksjc_pkg::ksjc_cell_ctrl_type        ctrl,
   input  logic                                enable,
   input  logic signed [ksjc_pkg::HEIGHT_W-1:0] stone_height,
   input  logic signed [ksjc_pkg::HEIGHT_W-1:0] left_height,
   input  logic [ksjc_pkg::COST_W-1:0]         left_cost,
   output logic signed [ksjc_pkg::HEIGHT_W-1:0] height_out,
   output logic [ksjc_pkg::COST_W-1:0]         cost_out,
   output logic [ksjc_pkg::COST_W-1:0]         candidate
);

   logic signed [ksjc_pkg::HEIGHT_W-1:0] height_ff;
   logic [ksjc_pkg::COST_W-1:0]         cost_ff;
   logic signed [ksjc_pkg::HEIGHT_W:0]   diff;
   logic [ksjc_pkg::HEIGHT_W-1:0]       jump_cost;
   logic [ksjc_pkg::COST_W:0]           sum;

   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         height_ff <= '0;
         cost_ff   <= '0;
      end else if (ctrl.shift) begin
         height_ff <= left_height;
         cost_ff   <= left_cost;
      end
   end

   // distance fits the height width as unsigned
   always_comb begin
      diff = {stone_height[ksjc_pkg::HEIGHT_W-1], stone_height}
           - {height_ff[ksjc_pkg::HEIGHT_W-1], height_ff};
      jump_cost = diff[ksjc_pkg::HEIGHT_W] ? ksjc_pkg::HEIGHT_W'(-diff)
                                           : diff[ksjc_pkg::HEIGHT_W-1:0];
      sum  = {1'b0, cost_ff}
           + {{(ksjc_pkg::COST_W + 1 - ksjc_pkg::HEIGHT_W){1'b0}}, jump_cost};
      if (!enable || sum[ksjc_pkg::COST_W]) begin
         candidate = ksjc_pkg::COST_TOP;
      end else begin
         candidate = sum[ksjc_pkg::COST_W-1:0];
      end
   end

   assign height_out = height_ff;
   assign cost_out   = cost_ff;

endmodule

// ===== src/ksjc_min_tree.sv =====
// iterative minimum over the cell candidates, halving the set each cycle in which ctrl.step is set
// uses ksjc_pkg
module ksjc_min_tree (
   input  logic                                             clock,
   input  ksjc_pkg::ksjc_tree_ctrl_type                     ctrl,
   input  logic [ksjc_pkg::MAX_JUMP-1:0][ksjc_pkg::COST_W-1:0] cand,
   output logic [ksjc_pkg::COST_W-1:0]                      min_cost
);

   logic [ksjc_pkg::COST_W-1:0] red_ff [ksjc_pkg::TREE_SIZE];
   logic [ksjc_pkg::COST_W-1:0] red_in [ksjc_pkg::TREE_SIZE];

   always_comb begin
      for (int i = 0; i < ksjc_pkg::TREE_SIZE; i++) begin
         red_in[i] = ksjc_pkg::COST_TOP;
      end
      if (ctrl.load) begin
         for (int i = 0; i < ksjc_pkg::MAX_JUMP; i++) begin
            red_in[i] = cand[i];
         end
      end else begin
         // pairwise minimum, result packed into the lower half
         for (int i = 0; i < ksjc_pkg::TREE_SIZE / 2; i++) begin
            red_in[i] = (red_ff[2*i+1] < red_ff[2*i]) ? red_ff[2*i+1] : red_ff[2*i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load || ctrl.step) begin
         for (int i = 0; i < ksjc_pkg::TREE_SIZE; i++) begin
            red_ff[i] <= red_in[i];
         end
      end
   end

   assign min_cost = red_ff[0];

endmodule

// ===== src/k_step_min_jump_cost_unit.sv =====
// top level of the k-step minimum jump cost unit: control, config register, output word
// depends on ksjc_pkg, ksjc_cell and ksjc_min_tree
//
//   port group   dir   handshake            word
//   req_         in    req_valid/req_stall  ksjc_req_type (height, last_stone)
//   rsp_         out   rsp_valid/rsp_stall  ksjc_rsp_type (reach_cost, is_final)
//   csr_         in    csr_write_enable     max_jump, 5 bits
//
// each stone passes through latch, candidate load, one step per level of the min
// reduction, then the window shift.
// the next stone needs the cost just found, so one stone is in flight at a time.
// reset is synchronous: windows and fill clear, max_jump returns to 2.
// a stalled result holds in the output register; a new stone is taken meanwhile
// and waits in the final step until the output register frees.
module k_step_min_jump_cost_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  ksjc_pkg::ksjc_req_type        req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output ksjc_pkg::ksjc_rsp_type        rsp_data,
   input  logic                          csr_write_enable,
   input  logic [ksjc_pkg::JUMP_W-1:0]   csr_write_data
);

   ksjc_pkg::ksjc_state_type state_ff, state_in;
   logic [ksjc_pkg::LVL_W-1:0]   level_ff, level_in;
   logic [ksjc_pkg::JUMP_W-1:0]  max_jump_ff;
   logic [ksjc_pkg::FILL_W-1:0]  fill_ff;
   ksjc_pkg::ksjc_req_type       stone_ff;
   logic                         rsp_valid_ff;
   ksjc_pkg::ksjc_rsp_type       rsp_data_ff;

   ksjc_pkg::ksjc_cell_ctrl_type cell_ctrl;
   ksjc_pkg::ksjc_tree_ctrl_type tree_ctrl;
   logic                         accept;
   logic                         out_free;
   logic                         finish;
   logic [ksjc_pkg::CMP_W-1:0]   eff_jump;
   logic [ksjc_pkg::CMP_W-1:0]   fill_ext;
   logic [ksjc_pkg::CMP_W-1:0]   limit;
   logic [ksjc_pkg::COST_W-1:0]  min_cost;
   logic [ksjc_pkg::COST_W-1:0]  new_cost;

   logic signed [ksjc_pkg::HEIGHT_W-1:0] chain_height [ksjc_pkg::MAX_JUMP+1];
   logic [ksjc_pkg::COST_W-1:0]         chain_cost   [ksjc_pkg::MAX_JUMP+1];
   logic [ksjc_pkg::MAX_JUMP-1:0][ksjc_pkg::COST_W-1:0] cand;

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // jump limit: zero acts as one, clipped to the window, then to the fill
   always_comb begin
      eff_jump = ksjc_pkg::CMP_W'(max_jump_ff);
      if (max_jump_ff == '0) begin
         eff_jump = ksjc_pkg::CMP_W'(1);
      end else if (ksjc_pkg::CMP_W'(max_jump_ff) > ksjc_pkg::CMP_W'(ksjc_pkg::MAX_JUMP)) begin
         eff_jump = ksjc_pkg::CMP_W'(ksjc_pkg::MAX_JUMP);
      end
      fill_ext = ksjc_pkg::CMP_W'(fill_ff);
      limit    = (fill_ext < eff_jump) ? fill_ext : eff_jump;
   end

   // first stone of a set has no predecessor
   assign new_cost = (fill_ff == '0) ? '0 : min_cost;

   assign chain_height[0] = stone_ff.height;
   assign chain_cost[0]   = new_cost;

   for (genvar j = 0; j < ksjc_pkg::MAX_JUMP; j++) begin : g_cell
      ksjc_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctrl         (cell_ctrl),
         .enable       (ksjc_pkg::CMP_W'(j) < limit),
         .stone_height (stone_ff.height),
         .left_height  (chain_height[j]),
         .left_cost    (chain_cost[j]),
         .height_out   (chain_height[j+1]),
         .cost_out     (chain_cost[j+1]),
         .candidate    (cand[j])
      );
   end

   ksjc_min_tree u_min_tree (
      .clock    (clock),
      .ctrl     (tree_ctrl),
      .cand     (cand),
      .min_cost (min_cost)
   );

   always_comb begin
      state_in        = state_ff;
      level_in        = level_ff;
      req_stall       = 1'b1;
      tree_ctrl.load  = 1'b0;
      tree_ctrl.step  = 1'b0;
      finish          = 1'b0;
      case (state_ff)
         ksjc_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               state_in = ksjc_pkg::ST_CAND;
            end
         end
         ksjc_pkg::ST_CAND: begin
            tree_ctrl.load = 1'b1;
            level_in       = '0;
            state_in       = ksjc_pkg::ST_REDUCE;
         end
         ksjc_pkg::ST_REDUCE: begin
            tree_ctrl.step = 1'b1;
            level_in       = level_ff + 1'b1;
            if (level_ff == ksjc_pkg::LVL_W'(ksjc_pkg::TREE_LEVELS - 1)) begin
               state_in = ksjc_pkg::ST_DONE;
            end
         end
         ksjc_pkg::ST_DONE: begin
            if (out_free) begin
               finish   = 1'b1;
               state_in = ksjc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ksjc_pkg::ST_IDLE;
         end
      endcase
      cell_ctrl.shift = finish;
      cell_ctrl.clear = finish && stone_ff.last_stone;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ksjc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      level_ff <= level_in;
      if (accept) begin
         stone_ff <= req_data;
      end
      if (finish) begin
         rsp_data_ff.reach_cost <= new_cost;
         rsp_data_ff.is_final   <= stone_ff.last_stone;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_jump_ff  <= ksjc_pkg::MAX_JUMP_RESET;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            max_jump_ff <= csr_write_data;
         end
         if (finish) begin
            if (stone_ff.last_stone) begin
               fill_ff <= '0;
            end else if (fill_ff != ksjc_pkg::FILL_W'(ksjc_pkg::MAX_JUMP)) begin
               fill_ff <= fill_ff + 1'b1;
            end
         end
         if (finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
